// File: hdl/cvl_pkg.sv
// Shared constants, codes and control types for the compacting value list.
package cvl_pkg;

	localparam int CAPACITY = 16;
	localparam int POS_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the accepted beat
		logic exec;   // run the operation and load the result register
	} ctl_cmd_t;

endpackage

// File: hdl/cvl_ctrl.sv
// Controller state machine: input handshake, execute step and output valid.
module cvl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output cvl_pkg::ctl_cmd_t ctl
);
	import cvl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		ctl.load = (state_q == S_IDLE) && s_axis_tvalid;
		ctl.exec = (state_q == S_EXEC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.load) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (ctl.exec) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (state_q == S_EXEC))
		else $error("load did not enter execute state");
	a_exec_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> m_axis_tvalid)
		else $error("execute step produced no output beat");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> (!out_valid_q || m_axis_tready))
		else $error("result register overwritten before taken");
`endif

endmodule

// File: hdl/cvl_dpath.sv
// Datapath: row of entry cells, parallel compare, first-match encoder, result register.
module cvl_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cvl_pkg::ctl_cmd_t                 ctl,
	input  logic [cvl_pkg::CMD_W-1:0]         in_cmd,
	input  logic [cvl_pkg::VALUE_W-1:0]       in_value,
	output logic [cvl_pkg::STATUS_W-1:0]      out_status,
	output logic [cvl_pkg::INDEX_W-1:0]       out_index,
	output logic [cvl_pkg::COUNT_W-1:0]       out_count
);
	import cvl_pkg::*;

	logic [VALUE_W-1:0]  entry_q [CAPACITY];
	logic [VALUE_W-1:0]  next_up [CAPACITY];
	logic [CNT_W-1:0]    held_q;
	logic [CNT_W-1:0]    held_d;
	logic [CMD_W-1:0]    cmd_q;
	logic [VALUE_W-1:0]  value_q;

	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] first_oh;
	logic [CAPACITY-1:0] ge_mask;
	logic                found;
	logic                full;
	logic [POS_W-1:0]    pos;
	logic [POS_W-1:0]    idx;
	status_t             st;
	logic                do_append;
	logic                do_remove;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= in_cmd;
			value_q <= in_value;
		end
	end

	// Compare every live cell against the key at once.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CNT_W'(i) < held_q) && (entry_q[i] == value_q);
		end
	end

	// Isolate the lowest match; everything at or above it shifts on remove.
	assign first_oh = match & (~match + 1'b1);
	assign found    = |match;
	assign ge_mask  = found ? ~(first_oh - 1'b1) : '0;
	assign full     = (held_q == CNT_W'(CAPACITY));

	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_oh[i]) pos = pos | POS_W'(i);
		end
	end

	always_comb begin
		st        = ST_OK;
		idx       = '0;
		held_d    = held_q;
		do_append = 1'b0;
		do_remove = 1'b0;
		case (cmd_q)
			CMD_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					do_append = 1'b1;
					held_d    = held_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					do_remove = 1'b1;
					idx       = pos;
					held_d    = held_q - 1'b1;
				end else begin
					st = ST_MISSING;
				end
			end
			default: begin
				// find, and the unused code decoded as find
				if (found) idx = pos;
				else       st  = ST_MISSING;
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g < CAPACITY - 1) begin : g_mid
			assign next_up[g] = entry_q[g+1];
		end else begin : g_top
			assign next_up[g] = entry_q[g];
		end

		always_ff @(posedge clk) begin
			if (ctl.exec) begin
				if (do_append && (held_q == CNT_W'(g))) begin
					entry_q[g] <= value_q;
				end else if (do_remove && ge_mask[g]) begin
					entry_q[g] <= next_up[g];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (ctl.exec) begin
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			out_status <= st;
			out_index  <= INDEX_W'(idx);
			out_count  <= COUNT_W'(held_d);
		end
	end

`ifndef SYNTHESIS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && (st != ST_OK)) |=> $stable(held_q))
		else $error("failed operation changed the count");
	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_oh) && (found == (first_oh != '0)))
		else $error("first-match encoder not one-hot");
`endif

endmodule

// File: hdl/compacting_value_list.sv
// Top level of the compacting value list: ports, controller and datapath.
//
//  beat        | port group | tuser            | tdata
//  ------------+------------+------------------+---------------------------------
//  command in  | s_axis_*   | [1:0] cmd        | [31:0] value
//  result out  | m_axis_*   | [1:0] status     | [3:0] index, [8:4] count, rest 0
//
// Each command is captured in the idle state; the execute state then compares all
// cells in parallel, shifts or writes the list and loads the result register.
// The result register is separate from the input side, so the next command
// is captured while a result still waits; a stalled result holds the execute
// step until it is taken. Reset clears the count and all handshake state; the
// list contents need no clearing since only live cells are ever compared.
module compacting_value_list (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [3:0] index, [8:4] count, [15:9] zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import cvl_pkg::*;

	ctl_cmd_t            ctl;
	logic [INDEX_W-1:0]  index;
	logic [COUNT_W-1:0]  count;

	// Handshake and sequencing.
	cvl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.ctl           (ctl)
	);

	// List storage and search.
	cvl_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.in_cmd     (s_axis_tuser),
		.in_value   (s_axis_tdata),
		.out_status (m_axis_tuser),
		.out_index  (index),
		.out_count  (count)
	);

	// Pack the result fields, lowest first; pad to a whole number of bytes.
	assign m_axis_tdata = {7'd0, count, index};

endmodule
